[hdl/least_loaded_core_picker_top_macros.svh]
// Assertion helpers for the core picker.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is high.
`ifndef LEAST_LOADED_CORE_PICKER_TOP_MACROS_SVH
`define LEAST_LOADED_CORE_PICKER_TOP_MACROS_SVH

// Same-cycle implication.
`define LLCP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llcp: same-cycle check failed");

// Next-cycle implication.
`define LLCP_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llcp: next-cycle check failed");

`endif

[hdl/llcp_pkg.sv]
// ----------------------------------------------------------------------------
// llcp_pkg
// Shared constants and types of the least-loaded core picker.
// ----------------------------------------------------------------------------
`default_nettype none

package llcp_pkg;

  localparam int LLCP_NUM_SLOTS = 64;
  localparam int LLCP_NUM_CORES = 64;

  localparam int MASK_W     = 64;
  localparam int CORE_IDX_W = 6;
  localparam int LOAD_W     = 7;
  localparam int CFG_IDX_W  = 3;

  localparam logic [LOAD_W-1:0] LOAD_MAX = 7'h7F;

  // Worker types that select a core group. Every other type is ungrouped.
  localparam logic [2:0] PT_NONE   = 3'd0;
  localparam logic [2:0] PT_UDP    = 3'd1;
  localparam logic [2:0] PT_TCP    = 3'd2;
  localparam logic [2:0] PT_TIMER  = 3'd3;
  localparam logic [2:0] PT_MODULE = 3'd4;

  // Response status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_SLOT = 1'b1;

  typedef enum logic [1:0] {
    OP_SPAWN   = 2'd0,
    OP_START   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } llcp_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN_ENABLE   = 3'd0,
    CFG_ALLOWED      = 3'd1,
    CFG_UDP_GROUP    = 3'd2,
    CFG_TCP_GROUP    = 3'd3,
    CFG_TIMER_GROUP  = 3'd4,
    CFG_MODULE_GROUP = 3'd5
  } llcp_cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SPAWN_WR,
    S_SLOT_RD,
    S_LOAD_RD,
    S_OUT
  } llcp_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  slot_index;
    logic [2:0]  worker_kind;
    logic [2:0]  group_override;
    logic        whole_group;
    logic        has_listener_list;
    logic [63:0] listener_cpus;
  } llcp_in_t;

  typedef struct packed {
    logic       status;
    logic [5:0] granted_slot;
    logic       core_valid;
    logic [5:0] core_index;
  } llcp_out_t;

  // One entry of the slot table.
  typedef struct packed {
    logic                  running;
    logic                  reserved;
    logic                  core_valid;
    logic [CORE_IDX_W-1:0] core;
  } llcp_slot_t;

endpackage

`default_nettype wire

[hdl/llcp_chan_if.sv]
// ----------------------------------------------------------------------------
// llcp_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface llcp_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

[hdl/least_loaded_core_picker_top.sv]
// ----------------------------------------------------------------------------
// least_loaded_core_picker_top
// Spawn: one pass over the slot and load memories, one entry a cycle, then the
// slot write and the result stage. Start or release: slot read, then, if the
// entry qualifies, a load read-modify-write. No-op and out-of-range slot:
// straight to the result stage. One item at a time; the next transfer is
// taken in the cycle after the result is staged, later while it waits.
// Reset (synchronous) runs a clearing pass over both memories; no input is
// taken until it ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "least_loaded_core_picker_top_macros.svh"

module least_loaded_core_picker_top #(
  parameter int NUM_SLOTS = llcp_pkg::LLCP_NUM_SLOTS,
  parameter int NUM_CORES = llcp_pkg::LLCP_NUM_CORES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  llcp_chan_if.sink                           req,
  llcp_chan_if.source                         rsp,
  input  wire logic                           cfg_we,
  input  wire logic [llcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [llcp_pkg::MASK_W-1:0]    cfg_wdata
);

  import llcp_pkg::*;

  // The scan walks slots and cores side by side with one shared counter.
  localparam int SCAN_LEN = (NUM_SLOTS > NUM_CORES) ? NUM_SLOTS : NUM_CORES;
  localparam int SCAN_W   = $clog2(SCAN_LEN + 1);
  localparam int SLOT_AW  = $clog2(NUM_SLOTS);
  localparam int CORE_AW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  // Mask bits at or above NUM_CORES never take part in a pick.
  localparam logic [MASK_W-1:0] CORE_MASK =
    (NUM_CORES >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << NUM_CORES) - 64'd1);

  // --------------------------------------------------------------------------
  // Config regs, written by the user only while idle; not enforced.
  // --------------------------------------------------------------------------
  logic              pin_enable;
  logic [MASK_W-1:0] allowed_cpus;
  logic [MASK_W-1:0] udp_group_cpus;
  logic [MASK_W-1:0] tcp_group_cpus;
  logic [MASK_W-1:0] timer_group_cpus;
  logic [MASK_W-1:0] module_group_cpus;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_enable        <= 1'b0;
      allowed_cpus      <= {MASK_W{1'b1}};
      udp_group_cpus    <= '0;
      tcp_group_cpus    <= '0;
      timer_group_cpus  <= '0;
      module_group_cpus <= '0;
    end else if (cfg_we) begin
      unique case (llcp_cfg_idx_t'(cfg_index))
        CFG_PIN_ENABLE:   pin_enable        <= cfg_wdata[0];
        CFG_ALLOWED:      allowed_cpus      <= cfg_wdata;
        CFG_UDP_GROUP:    udp_group_cpus    <= cfg_wdata;
        CFG_TCP_GROUP:    tcp_group_cpus    <= cfg_wdata;
        CFG_TIMER_GROUP:  timer_group_cpus  <= cfg_wdata;
        CFG_MODULE_GROUP: module_group_cpus <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State memories. The slot table holds running, reserved and the assigned
  // core of each slot; the load memory holds the occupancy count of each
  // core. Both have one write port and a registered read port.
  // --------------------------------------------------------------------------
  llcp_slot_t        slot_mem [NUM_SLOTS];
  logic [LOAD_W-1:0] load_mem [NUM_CORES];

  logic              slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  llcp_slot_t        slot_wdata;
  logic [SLOT_AW-1:0] slot_raddr;
  llcp_slot_t        slot_rdata;

  logic              load_we;
  logic [CORE_AW-1:0] load_waddr;
  logic [LOAD_W-1:0] load_wdata;
  logic [CORE_AW-1:0] load_raddr;
  logic [LOAD_W-1:0] load_rdata;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      load_mem[load_waddr] <= load_wdata;
    end
    load_rdata <= load_mem[load_raddr];
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  llcp_state_t       state;
  llcp_state_t       state_next;
  logic [SCAN_W-1:0] scan_cnt;
  logic [SCAN_W-1:0] scan_q;
  logic              scan_vld;

  llcp_op_t          op_q;
  logic [5:0]        slot_q;
  logic [MASK_W-1:0] pick_set;

  logic               found;
  logic [SLOT_AW-1:0] free_slot;
  logic               best_found;
  logic [CORE_IDX_W-1:0] best_idx;
  logic [LOAD_W-1:0]  min_load;

  logic [CORE_AW-1:0] ld_addr;
  logic               ld_inc;

  llcp_out_t res;
  llcp_out_t out_q;
  logic      out_valid;

  logic in_xfer;
  logic in_range;
  logic scan_live;
  logic clear_last;
  logic scan_last;
  logic out_free;

  assign in_xfer    = req.valid && req.ready;
  assign in_range   = 32'(req.data.slot_index) < NUM_SLOTS;
  assign scan_live  = 32'(scan_cnt) < SCAN_LEN;
  assign clear_last = scan_cnt == SCAN_W'(SCAN_LEN - 1);
  assign scan_last  = scan_vld && (scan_q == SCAN_W'(SCAN_LEN - 1));
  assign out_free   = !out_valid || rsp.ready;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  // --------------------------------------------------------------------------
  // Allowed-core set of a spawn, worked out from the request and the
  // configuration when the request is taken. An empty set stands for "no
  // core": whole-group requests, pinning off without a listener list, an
  // empty narrowed mask, and an ungrouped type while some group exists.
  // --------------------------------------------------------------------------
  logic [2:0]        gtype;
  logic [MASK_W-1:0] grp;
  logic              any_grp;
  logic [MASK_W-1:0] base_set;
  logic [MASK_W-1:0] new_set;

  always_comb begin
    gtype = (req.data.group_override != PT_NONE) ? req.data.group_override
                                                 : req.data.worker_kind;
    case (gtype)
      PT_UDP:    grp = udp_group_cpus;
      PT_TCP:    grp = tcp_group_cpus;
      PT_TIMER:  grp = timer_group_cpus;
      PT_MODULE: grp = module_group_cpus;
      default:   grp = '0;
    endcase
    grp      = grp & CORE_MASK;
    any_grp  = ((udp_group_cpus | tcp_group_cpus | timer_group_cpus |
                 module_group_cpus) & CORE_MASK) != '0;
    base_set = allowed_cpus & CORE_MASK;
    new_set  = '0;
    if (req.data.whole_group) begin
      new_set = '0;
    end else if (!pin_enable && !req.data.has_listener_list) begin
      new_set = '0;
    end else if (req.data.has_listener_list) begin
      new_set = base_set & req.data.listener_cpus;
    end else if (grp != '0) begin
      new_set = base_set & grp;
    end else if (any_grp) begin
      new_set = '0;
    end else begin
      new_set = base_set;
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          unique case (llcp_op_t'(req.data.opcode))
            OP_SPAWN:   state_next = S_SCAN;
            OP_START,
            OP_RELEASE: state_next = in_range ? S_SLOT_RD : S_OUT;
            OP_NOP:     state_next = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_SPAWN_WR;
        end
      end
      S_SPAWN_WR: state_next = S_OUT;
      S_SLOT_RD: begin
        if (op_q == OP_START) begin
          state_next = (!slot_rdata.running && slot_rdata.core_valid &&
                        (32'(slot_rdata.core) < NUM_CORES)) ? S_LOAD_RD : S_OUT;
        end else begin
          state_next = (slot_rdata.running && slot_rdata.core_valid &&
                        (32'(slot_rdata.core) < NUM_CORES)) ? S_LOAD_RD : S_OUT;
        end
      end
      S_LOAD_RD: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory port control. Each state touches each memory through at most one
  // port pair, and the read of an entry always lands before its write, so
  // no forwarding is needed.
  // --------------------------------------------------------------------------
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = '0;
    load_we    = 1'b0;
    load_waddr = '0;
    load_wdata = '0;
    load_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        // Zero one slot entry and one load counter per cycle.
        slot_we    = 32'(scan_cnt) < NUM_SLOTS;
        slot_waddr = scan_cnt[SLOT_AW-1:0];
        load_we    = 32'(scan_cnt) < NUM_CORES;
        load_waddr = scan_cnt[CORE_AW-1:0];
      end
      S_IDLE: begin
        slot_raddr = in_range ? SLOT_AW'(req.data.slot_index) : '0;
      end
      S_SCAN: begin
        slot_raddr = (32'(scan_cnt) < NUM_SLOTS) ? scan_cnt[SLOT_AW-1:0] : '0;
        load_raddr = (32'(scan_cnt) < NUM_CORES) ? scan_cnt[CORE_AW-1:0] : '0;
      end
      S_SPAWN_WR: begin
        // The new slot is reserved, not running, with the picked core.
        slot_we               = found;
        slot_waddr            = free_slot;
        slot_wdata.reserved   = 1'b1;
        slot_wdata.core_valid = best_found;
        slot_wdata.core       = best_found ? best_idx : '0;
      end
      S_SLOT_RD: begin
        slot_waddr = SLOT_AW'(slot_q);
        load_raddr = slot_rdata.core[CORE_AW-1:0];
        if (op_q == OP_START) begin
          slot_we            = !slot_rdata.running;
          slot_wdata         = slot_rdata;
          slot_wdata.running = 1'b1;
        end else begin
          // Release clears the whole entry.
          slot_we    = 1'b1;
          slot_wdata = '0;
        end
      end
      S_LOAD_RD: begin
        load_we    = 1'b1;
        load_waddr = ld_addr;
        if (ld_inc) begin
          load_wdata = (load_rdata == LOAD_MAX) ? load_rdata
                                                : load_rdata + LOAD_W'(1);
        end else begin
          load_wdata = (load_rdata == '0) ? load_rdata : load_rdata - LOAD_W'(1);
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      scan_cnt <= '0;
      scan_vld <= 1'b0;
    end else begin
      state    <= state_next;
      scan_vld <= (state == S_SCAN) && scan_live;
      if (state == S_CLEAR) begin
        scan_cnt <= clear_last ? '0 : scan_cnt + SCAN_W'(1);
      end else if (state == S_SCAN) begin
        if (scan_live) begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
        end
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_q <= scan_cnt;
  end

  // Request capture. The echoed result of a no-op or an out-of-range slot
  // is staged right away.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q     <= llcp_op_t'(req.data.opcode);
      slot_q   <= req.data.slot_index;
      pick_set <= new_set;
      res      <= '{status: ST_OK, granted_slot: req.data.slot_index,
                    core_valid: 1'b0, core_index: '0};
    end else if (state == S_SPAWN_WR) begin
      if (found) begin
        res <= '{status: ST_OK, granted_slot: 6'(free_slot),
                 core_valid: best_found, core_index: best_found ? best_idx : '0};
      end else begin
        res <= '{status: ST_NO_SLOT, granted_slot: '0, core_valid: 1'b0, core_index: '0};
      end
    end else if (state == S_SLOT_RD) begin
      res.core_valid <= slot_rdata.core_valid;
      res.core_index <= slot_rdata.core_valid ? slot_rdata.core : '0;
    end
  end

  // Scan results: the first free slot from slot 1 up, and the least loaded
  // core of the allowed set with the lowest index winning ties.
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      best_found <= 1'b0;
    end else if (in_xfer) begin
      found      <= 1'b0;
      best_found <= 1'b0;
    end else if (scan_vld) begin
      if (!found && (scan_q != '0) && (32'(scan_q) < NUM_SLOTS) &&
          !slot_rdata.running && !slot_rdata.reserved) begin
        found     <= 1'b1;
        free_slot <= scan_q[SLOT_AW-1:0];
      end
      if ((32'(scan_q) < NUM_CORES) && pick_set[CORE_IDX_W'(scan_q)] &&
          (!best_found || (load_rdata < min_load))) begin
        best_found <= 1'b1;
        best_idx   <= CORE_IDX_W'(scan_q);
        min_load   <= load_rdata;
      end
    end
  end

  // Load update target, set when the slot entry comes back.
  always_ff @(posedge clk) begin
    if (state == S_SLOT_RD) begin
      ld_addr <= slot_rdata.core[CORE_AW-1:0];
      ld_inc  <= (op_q == OP_START);
    end
  end

  // Output register: the finished result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_q <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A granted core always comes from the allowed set of the request.
  `LLCP_ASSERT_IMP(a_pick_in_set, clk, rst, state == S_SPAWN_WR && best_found, pick_set[best_idx])
  // Slot zero is never handed out by a spawn.
  `LLCP_ASSERT_IMP(a_no_slot_zero, clk, rst, state == S_SPAWN_WR && found, free_slot != SLOT_AW'(0))
  // The scan only reads; the state does not change under it.
  `LLCP_ASSERT_IMP(a_scan_read_only, clk, rst, state == S_SCAN, !slot_we && !load_we)
  // A picked load read-modify-write is followed by the result stage.
  `LLCP_ASSERT_NXT(a_load_then_out, clk, rst, state == S_LOAD_RD, state == S_OUT)

endmodule

`default_nettype wire
